// File: rtl/core/fmis_pkg.sv
// fmis_pkg: shared types and constants for the first-match index search unit
// no dependencies; imported by fmis_cell and first_match_index_search_unit

package fmis_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned POS_W   = 11;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    // item kinds carried in tuser
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // register index of index_origin (paddr[2])
    localparam logic REG_ORIGIN = 1'b0;

    // search token handed from one cell to the next
    typedef struct packed {
        logic val;
        logic fnd;
    } t_link;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

endpackage

// File: rtl/core/fmis_cell.sv
// fmis_cell: one table entry plus one stage of the search chain
// depends on fmis_pkg for the link type and data width

module fmis_cell #(
    parameter int unsigned CW  = 11,
    parameter int unsigned IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [CW-1:0]              i_wr_idx,
    input  logic [fmis_pkg::DATA_W-1:0] i_wr_data,
    input  logic [fmis_pkg::DATA_W-1:0] i_qval,
    input  logic [CW-1:0]              i_count,
    input  fmis_pkg::t_link            i_link,
    input  logic [CW-1:0]              i_pos,
    output fmis_pkg::t_link            o_link,
    output logic [CW-1:0]              o_pos
);
    import fmis_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DATA_W-1:0] r_data;
    t_link             r_link;
    t_link             n_link;
    logic [CW-1:0]     r_pos;
    logic [CW-1:0]     n_pos;
    logic              hit;

    // only entries below the count take part, those were written since the last clear
    assign hit = i_link.val && !i_link.fnd && (MY_IDX < i_count) && (r_data == i_qval);

    always_comb begin
        n_link.val = i_link.val;
        n_link.fnd = i_link.fnd | hit;
        n_pos      = hit ? MY_IDX : i_pos;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_link = r_link;
    assign o_pos  = r_pos;

endmodule

// File: rtl/core/first_match_index_search_unit.sv
// first_match_index_search_unit: index-of search over signed 64-bit values
// depends on fmis_pkg and fmis_cell (one cell per table entry)
//
//  channel   | signals                          | direction | contents
//  ----------+----------------------------------+-----------+---------------------------
//  s_axis    | tvalid tready tdata tuser        | in        | tuser: mode, tdata: value
//  m_axis    | tvalid tready tdata              | out       | position, found, full_res
//  apb       | psel penable pwrite paddr ...    | in/out    | index_origin at address 0
//
// clear, append and unused-mode items pass through the staging register and then
// the output register. a query token walks the cell chain one cell per cycle and
// picks up the lowest matching entry on its way. one item is in work at a time; a
// finished result may wait in the output register while the next item is taken.
// reset is synchronous, active low, and empties the table and sets index_origin
// to one.

module first_match_index_search_unit #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // stream in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [63:0]                  s_axis_tdata,   // [63:0] value
    input  logic [1:0]                   s_axis_tuser,   // [1:0] mode
    // stream out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,   // [10:0] position, [11] found,
                                                         // [12] full_res, [15:13] zero
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fmis_pkg::APB_AW-1:0]  paddr,
    input  logic [fmis_pkg::APB_DW-1:0]  pwdata,
    output logic [fmis_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import fmis_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned SW = (CW > POS_W) ? CW + 1 : POS_W + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_origin;
    logic [DATA_W-1:0] r_qval;
    logic              r_launch;
    logic              n_launch;
    logic              r_pend;
    logic              n_pend;
    logic [POS_W-1:0]  r_pend_pos;
    logic [POS_W-1:0]  n_pend_pos;
    logic              r_pend_fnd;
    logic              n_pend_fnd;
    logic              r_pend_full;
    logic              n_pend_full;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [OUT_W-1:0]  n_out_data;

    logic              in_xfer;
    logic              cfg_wr;
    logic              wr_en;
    logic              out_free;
    logic [SW-1:0]     cnt_sum;
    logic [SW-1:0]     hit_sum;

    t_link             link [TABLE_DEPTH+1];
    logic [CW-1:0]     pos  [TABLE_DEPTH+1];

    // ---------------- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= 1'b1;
        end else if (cfg_wr && (paddr[2] == REG_ORIGIN)) begin
            r_origin <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ORIGIN) begin
            prdata[0] = r_origin;
        end
    end

    // ---------------- state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (s_axis_tuser == MODE_QUERY)) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (link[TABLE_DEPTH].val) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_IDLE:   s_axis_tready = !r_pend;
            ST_SEARCH: s_axis_tready = 1'b0;
            default:   s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- item handling and result staging
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign cnt_sum  = SW'(r_count) + SW'(r_origin);
    assign hit_sum  = SW'(pos[TABLE_DEPTH]) + SW'(r_origin);
    assign wr_en    = in_xfer && (s_axis_tuser == MODE_APPEND) && (r_count < DEPTH_C);

    always_comb begin
        n_count     = r_count;
        n_launch    = 1'b0;
        n_pend      = r_pend;
        n_pend_pos  = r_pend_pos;
        n_pend_fnd  = r_pend_fnd;
        n_pend_full = r_pend_full;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // hand a staged result to the output register
        if (out_free) begin
            n_out_valid = r_pend;
            if (r_pend) begin
                n_out_data = {3'b000, r_pend_full, r_pend_fnd, r_pend_pos};
                n_pend     = 1'b0;
            end
        end

        if (in_xfer) begin
            case (s_axis_tuser)
                MODE_CLEAR: begin
                    n_count     = '0;
                    n_pend      = 1'b1;
                    n_pend_pos  = '0;
                    n_pend_fnd  = 1'b0;
                    n_pend_full = 1'b0;
                end
                MODE_APPEND: begin
                    n_pend      = 1'b1;
                    n_pend_pos  = cnt_sum[POS_W-1:0];
                    n_pend_fnd  = 1'b0;
                    if (r_count < DEPTH_C) begin
                        n_count     = r_count + CW'(1);
                        n_pend_full = 1'b0;
                    end else begin
                        n_pend_full = 1'b1;
                    end
                end
                MODE_QUERY: begin
                    n_launch = 1'b1;
                end
                default: begin
                    n_pend      = 1'b1;
                    n_pend_pos  = '0;
                    n_pend_fnd  = 1'b0;
                    n_pend_full = 1'b0;
                end
            endcase
        end

        // token left the last cell
        if ((r_state == ST_SEARCH) && link[TABLE_DEPTH].val) begin
            n_pend      = 1'b1;
            n_pend_pos  = hit_sum[POS_W-1:0];
            n_pend_fnd  = link[TABLE_DEPTH].fnd;
            n_pend_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_launch    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_launch    <= n_launch;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_pos  <= n_pend_pos;
        r_pend_fnd  <= n_pend_fnd;
        r_pend_full <= n_pend_full;
        r_out_data  <= n_out_data;
        if (in_xfer && (s_axis_tuser == MODE_QUERY)) begin
            r_qval <= s_axis_tdata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- cell chain
    // token starts with the count as its position, so a miss reports the count plus index_origin
    assign link[0].val = r_launch;
    assign link[0].fnd = 1'b0;
    assign pos[0]      = r_count;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        fmis_cell #(
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (wr_en),
            .i_wr_idx  (r_count),
            .i_wr_data (s_axis_tdata),
            .i_qval    (r_qval),
            .i_count   (r_count),
            .i_link    (link[g]),
            .i_pos     (pos[g]),
            .o_link    (link[g+1]),
            .o_pos     (pos[g+1])
        );
    end

endmodule

// File: bench/tb_first_match_index_search_unit.sv
// tb_first_match_index_search_unit: self-checking bench for the first-match index search unit
// depends on fmis_pkg and first_match_index_search_unit; a table mirror predicts every
// result, with random gaps on both streams and index_origin changes over the apb port

module tb_first_match_index_search_unit;

    import fmis_pkg::*;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] ORIGIN_ADDR = {REG_ORIGIN, 2'b00};

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
        logic             full_res;
    } t_search_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    logic [MODE_W-1:0]   s_axis_tuser = MODE_CLEAR;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // mirror of the table, the entry count and the origin register
    logic [DATA_W-1:0]   mirror_table [TABLE_DEPTH];
    int unsigned         mirror_count = 0;
    logic                mirror_origin = 1'b1;

    t_search_res         queued_search_results [$];
    int unsigned         n_fail = 0;
    int unsigned         in_gap_max = 10;
    int unsigned         out_gap_max = 10;

    first_match_index_search_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [63:0] value
        .s_axis_tuser  (s_axis_tuser),   // [1:0] mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [10:0] position, [11] found, [12] full_res
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_search_res predict_index_of(input logic [MODE_W-1:0] mode,
                                                     input logic [DATA_W-1:0] value);
        t_search_res res;
        int unsigned hit;
        res = '0;
        case (mode)
            MODE_CLEAR: begin
                mirror_count = 0;
            end
            MODE_APPEND: begin
                res.position = POS_W'(mirror_count + mirror_origin);
                if (mirror_count < TABLE_DEPTH) begin
                    mirror_table[mirror_count] = value;
                    mirror_count++;
                end else begin
                    res.full_res = 1'b1;
                end
            end
            MODE_QUERY: begin
                hit = mirror_count;
                for (int i = 0; i < mirror_count; i++) begin
                    if (mirror_table[i] == value) begin
                        hit = i;
                        res.found = 1'b1;
                        break;
                    end
                end
                res.position = POS_W'(hit + mirror_origin);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_fail++;
        end
    endfunction

    function automatic logic [DATA_W-1:0] draw_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                case ($urandom_range(0, 5))
                    0:       v = 64'h8000_0000_0000_0000;
                    1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
                    2:       v = 64'h0;
                    3:       v = 64'hFFFF_FFFF_FFFF_FFFF;
                    4:       v = 64'h8000_0000_0000_0001;
                    default: v = 64'h0000_0001_0000_0000;
                endcase
            end
            3, 4, 5: begin
                // small magnitudes so that duplicates are common
                v = 64'($urandom_range(0, 7));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] draw_query_value();
        if (mirror_count > 0 && $urandom_range(0, 1) == 1)
            return mirror_table[$urandom_range(0, mirror_count - 1)];
        return draw_value();
    endfunction

    // leaves tvalid high so that a back-to-back item keeps the stream busy
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        queued_search_results.push_back(predict_index_of(mode, value));
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (queued_search_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_origin(input logic origin_bit);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ORIGIN_ADDR;
        pwdata  <= {31'($urandom), origin_bit};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror_origin = origin_bit;
        @(posedge i_clk);
    endtask

    task automatic check_origin_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ORIGIN_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        check_field("index_origin", mirror_origin, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_basic_search();
        check_origin_readback();
        send_item(MODE_QUERY, 64'h0);
        send_item(MODE_APPEND, 64'h8000_0000_0000_0000);
        send_item(MODE_APPEND, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(MODE_APPEND, 64'h0);
        send_item(MODE_APPEND, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_APPEND, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(MODE_QUERY, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(MODE_QUERY, 64'h8000_0000_0000_0000);
        send_item(MODE_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_QUERY, 64'h1);
        send_item(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_QUERY, 64'h0);
        send_item(MODE_CLEAR, 64'h5555_AAAA_5555_AAAA);
        // stale entries after a clear must not match
        send_item(MODE_QUERY, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(MODE_APPEND, 64'h5);
    endtask

    task automatic test_zero_origin();
        drain_block();
        write_origin(1'b0);
        check_origin_readback();
        send_item(MODE_QUERY, 64'h5);
        send_item(MODE_QUERY, 64'hAAAA_5555_AAAA_5555);
        send_item(MODE_APPEND, 64'h5);
        send_item(MODE_QUERY, 64'h5);
        send_item(MODE_CLEAR, 64'h0);
        drain_block();
        write_origin(1'b1);
        check_origin_readback();
    endtask

    task automatic test_full_table();
        logic [DATA_W-1:0] first_val;
        logic [DATA_W-1:0] last_val;
        logic [DATA_W-1:0] value;
        // bits 31:10 of every fill value are zero, so this one is absent
        logic [DATA_W-1:0] absent_val;
        absent_val = 64'h0000_0000_FFFF_FC00;
        first_val = '0;
        last_val = '0;
        send_item(MODE_CLEAR, draw_value());
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            value = {32'($urandom), 22'h0, 10'(i)};
            if (i == 0)
                first_val = value;
            last_val = value;
            send_item(MODE_APPEND, value);
        end
        send_item(MODE_APPEND, draw_value());
        send_item(MODE_APPEND, last_val);
        send_item(MODE_QUERY, first_val);
        send_item(MODE_QUERY, last_val);
        send_item(MODE_QUERY, absent_val);
        drain_block();
        write_origin(1'b0);
        send_item(MODE_APPEND, draw_value());
        send_item(MODE_QUERY, absent_val);
        send_item(MODE_QUERY, last_val);
        send_item(MODE_QUERY, draw_query_value());
        send_item(MODE_CLEAR, draw_value());
        drain_block();
        write_origin(1'b1);
    endtask

    task automatic test_random_traffic();
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] value;
        int unsigned       r;
        for (int blk = 0; blk < 9; blk++) begin
            case (blk)
                0: begin
                    in_gap_max  = 10;
                    out_gap_max = 10;
                end
                1: begin
                    in_gap_max  = 0;
                    out_gap_max = 0;
                end
                default: begin
                    in_gap_max  = ($urandom_range(0, 1) == 1) ? 10 : 0;
                    out_gap_max = ($urandom_range(0, 1) == 1) ? 10 : 0;
                end
            endcase
            // sender holds off until the block is empty, then flips the origin
            if (blk % 3 == 2) begin
                drain_block();
                write_origin(~mirror_origin);
                check_origin_readback();
            end
            for (int n = 0; n < 20; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    mode  = MODE_CLEAR;
                    value = {$urandom, $urandom};
                end else if (r < 52) begin
                    mode  = MODE_APPEND;
                    value = draw_value();
                end else if (r < 94) begin
                    mode  = MODE_QUERY;
                    value = draw_query_value();
                end else begin
                    mode  = MODE_UNUSED;
                    value = {$urandom, $urandom};
                end
                send_item(mode, value);
            end
        end
        in_gap_max  = 10;
        out_gap_max = 10;
    endtask

    // result side: random stall before each transfer, then compare with the oldest prediction
    initial begin
        t_search_res want;
        int unsigned stall;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = $urandom_range(0, out_gap_max);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if (queued_search_results.size() == 0) begin
                $error("result transfer with no item pending: tdata %h", m_axis_tdata);
                n_fail++;
            end else begin
                want = queued_search_results.pop_front();
                check_field("position", want.position, m_axis_tdata[POS_W-1:0]);
                check_field("found", want.found, m_axis_tdata[POS_W]);
                check_field("full_res", want.full_res, m_axis_tdata[POS_W+1]);
                check_field("pad", 0, m_axis_tdata[OUT_W-1:POS_W+2]);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_search();
        test_zero_origin();
        test_full_table();
        test_random_traffic();
        drain_block();
        repeat (TABLE_DEPTH + 16) @(posedge i_clk);
        if (n_fail == 0 && queued_search_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/fmis_pkg.sv
rtl/core/fmis_cell.sv
rtl/core/first_match_index_search_unit.sv
bench/tb_first_match_index_search_unit.sv
